### rtl/circle_circle_intersection_core_macros.svh
// Assertion macros for the circle intersection core.
// Needs clk and rst_n in scope at the point of use.
`ifndef CIRCLE_CIRCLE_INTERSECTION_CORE_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_CORE_MACROS_SVH
`ifndef SYNTH
`define CCI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cci: implication check failed");
`define CCI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cci: next-cycle check failed");
`else
`define CCI_ASSERT_IMP(label, ante, cons)
`define CCI_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/cci_pkg.sv
// Shared types and widths for the circle intersection core.
// No dependencies.
`timescale 1ns / 1ps
package cci_pkg;

    localparam int COORD_W      = 32;
    localparam int RAD_W        = 31;
    localparam int IN_TDATA_W   = 192;
    localparam int OUT_TDATA_W  = 128;
    localparam int STATUS_W     = 2;
    localparam int D2_W         = 64;
    localparam int ROOT_W       = 64;
    localparam int QUO_W        = 34;
    localparam int NUM_LANES    = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FAR    = 2'd1,
        ST_INSIDE = 2'd2,
        ST_SAME   = 2'd3
    } status_t;

    // geometry carried alongside the root pipe
    typedef struct packed {
        status_t                     status;
        logic                        x_sub;   // mid x goes toward -x
        logic                        y_sub;
        logic                        dx_neg;
        logic                        dy_pos;
        logic signed [COORD_W-1:0]   x0;
        logic signed [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]          adx;
        logic [COORD_W-1:0]          ady;
        logic [D2_W-1:0]             km;
        logic [D2_W-1:0]             d2;
    } geo_t;

    // what the final stages still need
    typedef struct packed {
        status_t                     status;
        logic                        x_sub;
        logic                        y_sub;
        logic                        dx_neg;
        logic                        dy_pos;
        logic signed [COORD_W-1:0]   x0;
        logic signed [COORD_W-1:0]   y0;
    } fin_t;

endpackage

### rtl/circle_circle_intersection_core.sv
// Circle-circle intersection core, top level: front stages, root, dividers, output.
// Depends on cci_pkg, cci_sqrt_pipe, cci_div_pipe and the macros header.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | x0 32, y0 32, r0 31, x1 32, y1 32, r1 31, 0 | -
//  m_axis   | out | a_x 32, a_y 32, b_x 32, b_y 32              | status 2
//
// One word per cycle in and out while the output is not stalled; 6 front stages, 64 root
// stages, 2 product stages, 34 divider stages, 2 output stages.
// The 64-stage root and 34-stage dividers set the depth.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// When a result sits unclaimed in the output register the whole pipe holds
// and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "circle_circle_intersection_core_macros.svh"
module circle_circle_intersection_core
    import cci_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // x0[31:0] y0[63:32] r0[94:64] x1[126:95] y1[158:127] r1[189:159], pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // a_x[31:0] a_y[63:32] b_x[95:64] b_y[127:96]
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]     m_axis_tuser
);

    localparam int NUM_W = D2_W + QUO_W;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [35:0] v);
        logic [COORD_W-1:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic en;

    // ---------------- stage 1: differences, magnitudes
    logic [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [RAD_W-1:0]   in_r0, in_r1;
    logic [COORD_W:0]   dx_w, dy_w;
    logic               s1_vld_reg;
    logic [COORD_W-1:0] s1_x0_reg, s1_y0_reg, s1_adx_reg, s1_ady_reg, s1_sum_reg;
    logic               s1_dxneg_reg, s1_dyneg_reg, s1_dypos_reg;
    logic [RAD_W-1:0]   s1_dif_reg, s1_r0_reg, s1_r1_reg;

    assign in_x0 = s_axis_tdata[31:0];
    assign in_y0 = s_axis_tdata[63:32];
    assign in_r0 = s_axis_tdata[94:64];
    assign in_x1 = s_axis_tdata[126:95];
    assign in_y1 = s_axis_tdata[158:127];
    assign in_r1 = s_axis_tdata[189:159];
    assign dx_w  = {in_x1[31], in_x1} - {in_x0[31], in_x0};
    assign dy_w  = {in_y1[31], in_y1} - {in_y0[31], in_y0};

    // ---------------- stage 2: squares
    logic               s2_vld_reg;
    logic [D2_W-1:0]    s2_sqx_reg, s2_sqy_reg, s2_sum2_reg, s2_dif2_reg, s2_a2_reg, s2_b2_reg;
    logic [COORD_W-1:0] s2_x0_reg, s2_y0_reg, s2_adx_reg, s2_ady_reg;
    logic               s2_dxneg_reg, s2_dyneg_reg, s2_dypos_reg;

    // ---------------- stage 3: squared distance, r0^2 - r1^2
    logic [D2_W:0]      d2_w;
    logic               s3_vld_reg, s3_ovf_reg, s3_abge_reg;
    logic [D2_W-1:0]    s3_d2_reg, s3_abd_reg, s3_sum2_reg, s3_dif2_reg;
    logic [COORD_W-1:0] s3_x0_reg, s3_y0_reg, s3_adx_reg, s3_ady_reg;
    logic               s3_dxneg_reg, s3_dyneg_reg, s3_dypos_reg;

    // ---------------- stage 4: status, K, root factors
    status_t            st_next;
    logic [D2_W-1:0]    km_next;
    logic               kneg_next;
    logic               s4_vld_reg;
    geo_t               s4_geo_reg;
    logic [D2_W-1:0]    s4_ha_reg, s4_hb_reg;

    // ---------------- stage 5/6: H = A * B in partial products
    logic               s5_vld_reg, s6_vld_reg;
    geo_t               s5_geo_reg, s6_geo_reg;
    logic [D2_W-1:0]    s5_pll_reg, s5_plh_reg, s5_phl_reg, s5_phh_reg;
    logic [2*D2_W-1:0]  s6_h_reg;

    // ---------------- root
    logic               sq_vld;
    logic [ROOT_W-1:0]  sq_root;
    logic [$bits(geo_t)-1:0] sq_sb;
    geo_t               sq_geo;

    // ---------------- stage 7/8: numerators
    logic               s7_vld_reg, s8_vld_reg;
    fin_t               s7_fin_reg, s8_fin_reg;
    logic [D2_W-1:0]    s7_d2_reg, s8_d2_reg;
    logic [D2_W-1:0]    s7_lo_reg [NUM_LANES];
    logic [D2_W-1:0]    s7_hi_reg [NUM_LANES];
    logic [NUM_W-1:0]   s8_num_reg [NUM_LANES];
    logic [COORD_W-1:0] mul_a [NUM_LANES];
    logic [D2_W-1:0]    mul_b [NUM_LANES];

    // ---------------- dividers
    logic               dv_vld;
    logic [QUO_W-1:0]   dv_quo [NUM_LANES];
    logic [$bits(fin_t)-1:0] dv_sb;
    fin_t               dv_fin;

    // ---------------- stage 9/10: midpoint, offsets, points
    logic               s9_vld_reg;
    status_t            s9_status_reg;
    logic signed [34:0] s9_x2_reg, s9_y2_reg;
    logic signed [33:0] s9_rx_reg, s9_ry_reg;
    logic signed [34:0] x2_next, y2_next;
    logic signed [33:0] rx_next, ry_next;
    logic signed [34:0] x0_ext, y0_ext, mx_ext, my_ext;
    logic signed [33:0] ox_ext, oy_ext;
    logic signed [35:0] ax_w, ay_w, bx_w, by_w;
    logic               out_vld_reg;
    status_t            out_status_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // whole pipe advances unless a result is stuck at the output
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= sq_vld;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= dv_vld;
            out_vld_reg <= s9_vld_reg;
        end
    end

    // ---------------- front datapath
    always_comb
    begin
        d2_w = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    end

    always_comb
    begin
        priority if (s3_ovf_reg || (s3_d2_reg > s3_sum2_reg))
            st_next = ST_FAR;
        else if (s3_d2_reg < s3_dif2_reg)
            st_next = ST_INSIDE;
        else if (s3_d2_reg == '0)
            st_next = ST_SAME;
        else
            st_next = ST_OK;

        // K = r0^2 - r1^2 + D2 as sign and magnitude
        priority if (s3_abge_reg)
        begin
            km_next   = s3_d2_reg + s3_abd_reg;
            kneg_next = 1'b0;
        end
        else if (s3_d2_reg >= s3_abd_reg)
        begin
            km_next   = s3_d2_reg - s3_abd_reg;
            kneg_next = 1'b0;
        end
        else
        begin
            km_next   = s3_abd_reg - s3_d2_reg;
            kneg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            s1_x0_reg    <= in_x0;
            s1_y0_reg    <= in_y0;
            s1_adx_reg   <= dx_w[COORD_W] ? COORD_W'(~dx_w + 1'b1) : dx_w[COORD_W-1:0];
            s1_ady_reg   <= dy_w[COORD_W] ? COORD_W'(~dy_w + 1'b1) : dy_w[COORD_W-1:0];
            s1_dxneg_reg <= dx_w[COORD_W];
            s1_dyneg_reg <= dy_w[COORD_W];
            s1_dypos_reg <= !dy_w[COORD_W] && (dy_w != '0);
            s1_sum_reg   <= {1'b0, in_r0} + {1'b0, in_r1};
            s1_dif_reg   <= (in_r0 >= in_r1) ? in_r0 - in_r1 : in_r1 - in_r0;
            s1_r0_reg    <= in_r0;
            s1_r1_reg    <= in_r1;

            // stage 2
            s2_sqx_reg   <= s1_adx_reg * s1_adx_reg;
            s2_sqy_reg   <= s1_ady_reg * s1_ady_reg;
            s2_sum2_reg  <= s1_sum_reg * s1_sum_reg;
            s2_dif2_reg  <= {33'b0, s1_dif_reg} * {33'b0, s1_dif_reg};
            s2_a2_reg    <= {33'b0, s1_r0_reg} * {33'b0, s1_r0_reg};
            s2_b2_reg    <= {33'b0, s1_r1_reg} * {33'b0, s1_r1_reg};
            s2_x0_reg    <= s1_x0_reg;
            s2_y0_reg    <= s1_y0_reg;
            s2_adx_reg   <= s1_adx_reg;
            s2_ady_reg   <= s1_ady_reg;
            s2_dxneg_reg <= s1_dxneg_reg;
            s2_dyneg_reg <= s1_dyneg_reg;
            s2_dypos_reg <= s1_dypos_reg;

            // stage 3
            s3_d2_reg    <= d2_w[D2_W-1:0];
            s3_ovf_reg   <= d2_w[D2_W];
            s3_abge_reg  <= (s2_a2_reg >= s2_b2_reg);
            s3_abd_reg   <= (s2_a2_reg >= s2_b2_reg) ? s2_a2_reg - s2_b2_reg
                                                      : s2_b2_reg - s2_a2_reg;
            s3_sum2_reg  <= s2_sum2_reg;
            s3_dif2_reg  <= s2_dif2_reg;
            s3_x0_reg    <= s2_x0_reg;
            s3_y0_reg    <= s2_y0_reg;
            s3_adx_reg   <= s2_adx_reg;
            s3_ady_reg   <= s2_ady_reg;
            s3_dxneg_reg <= s2_dxneg_reg;
            s3_dyneg_reg <= s2_dyneg_reg;
            s3_dypos_reg <= s2_dypos_reg;

            // stage 4
            s4_geo_reg.status <= st_next;
            s4_geo_reg.x_sub  <= s3_dxneg_reg ^ kneg_next;
            s4_geo_reg.y_sub  <= s3_dyneg_reg ^ kneg_next;
            s4_geo_reg.dx_neg <= s3_dxneg_reg;
            s4_geo_reg.dy_pos <= s3_dypos_reg;
            s4_geo_reg.x0     <= s3_x0_reg;
            s4_geo_reg.y0     <= s3_y0_reg;
            s4_geo_reg.adx    <= s3_adx_reg;
            s4_geo_reg.ady    <= s3_ady_reg;
            s4_geo_reg.km     <= km_next;
            s4_geo_reg.d2     <= s3_d2_reg;
            s4_ha_reg         <= s3_sum2_reg - s3_d2_reg;
            s4_hb_reg         <= s3_d2_reg - s3_dif2_reg;

            // stage 5: 32x32 partials of A * B
            s5_geo_reg <= s4_geo_reg;
            s5_pll_reg <= s4_ha_reg[31:0]  * s4_hb_reg[31:0];
            s5_plh_reg <= s4_ha_reg[31:0]  * s4_hb_reg[63:32];
            s5_phl_reg <= s4_ha_reg[63:32] * s4_hb_reg[31:0];
            s5_phh_reg <= s4_ha_reg[63:32] * s4_hb_reg[63:32];

            // stage 6
            s6_geo_reg <= s5_geo_reg;
            s6_h_reg   <= {s5_phh_reg, s5_pll_reg}
                        + {32'b0, s5_plh_reg, 32'b0}
                        + {32'b0, s5_phl_reg, 32'b0};
        end
    end

    // ---------------- root
    cci_sqrt_pipe #(
        .RADICAND_W (2 * ROOT_W),
        .SB_W       ($bits(geo_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_vld_reg),
        .radicand  (s6_h_reg),
        .sb_in     (s6_geo_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .sb_out    (sq_sb)
    );

    assign sq_geo = geo_t'(sq_sb);

    // lanes: mid x, mid y, offset x, offset y
    always_comb
    begin
        mul_a[0] = sq_geo.adx;  mul_b[0] = sq_geo.km;
        mul_a[1] = sq_geo.ady;  mul_b[1] = sq_geo.km;
        mul_a[2] = sq_geo.ady;  mul_b[2] = sq_root;
        mul_a[3] = sq_geo.adx;  mul_b[3] = sq_root;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_fin_reg.status <= sq_geo.status;
            s7_fin_reg.x_sub  <= sq_geo.x_sub;
            s7_fin_reg.y_sub  <= sq_geo.y_sub;
            s7_fin_reg.dx_neg <= sq_geo.dx_neg;
            s7_fin_reg.dy_pos <= sq_geo.dy_pos;
            s7_fin_reg.x0     <= sq_geo.x0;
            s7_fin_reg.y0     <= sq_geo.y0;
            s7_d2_reg         <= sq_geo.d2;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                s7_lo_reg[l] <= mul_a[l] * mul_b[l][31:0];
                s7_hi_reg[l] <= mul_a[l] * mul_b[l][63:32];
            end

            // numerator + D2 gives round-half-up after the final halving
            s8_fin_reg <= s7_fin_reg;
            s8_d2_reg  <= s7_d2_reg;
            for (int l = 0; l < NUM_LANES; l++)
                s8_num_reg[l] <= {2'b0, s7_hi_reg[l], 32'b0}
                               + {34'b0, s7_lo_reg[l]}
                               + {34'b0, s7_d2_reg};
        end
    end

    // ---------------- dividers
    cci_div_pipe #(
        .DEN_W (D2_W),
        .QW    (QUO_W),
        .LANES (NUM_LANES),
        .SB_W  ($bits(fin_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s8_vld_reg),
        .num       (s8_num_reg),
        .den       (s8_d2_reg),
        .sb_in     (s8_fin_reg),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .sb_out    (dv_sb)
    );

    assign dv_fin = fin_t'(dv_sb);

    // ---------------- midpoint and perpendicular offset
    always_comb
    begin
        x0_ext = 35'(dv_fin.x0);
        y0_ext = 35'(dv_fin.y0);
        mx_ext = $signed({2'b0, dv_quo[0][QUO_W-1:1]});
        my_ext = $signed({2'b0, dv_quo[1][QUO_W-1:1]});
        ox_ext = $signed({1'b0, dv_quo[2][QUO_W-1:1]});
        oy_ext = $signed({1'b0, dv_quo[3][QUO_W-1:1]});
        x2_next = dv_fin.x_sub ? x0_ext - mx_ext : x0_ext + mx_ext;
        y2_next = dv_fin.y_sub ? y0_ext - my_ext : y0_ext + my_ext;
        rx_next = dv_fin.dy_pos ? -ox_ext : ox_ext;
        ry_next = dv_fin.dx_neg ? -oy_ext : oy_ext;
    end

    always_comb
    begin
        ax_w = 36'(s9_x2_reg) + 36'(s9_rx_reg);
        ay_w = 36'(s9_y2_reg) + 36'(s9_ry_reg);
        bx_w = 36'(s9_x2_reg) - 36'(s9_rx_reg);
        by_w = 36'(s9_y2_reg) - 36'(s9_ry_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_status_reg  <= dv_fin.status;
            s9_x2_reg      <= x2_next;
            s9_y2_reg      <= y2_next;
            s9_rx_reg      <= rx_next;
            s9_ry_reg      <= ry_next;
            out_status_reg <= s9_status_reg;
            if (s9_status_reg == ST_OK)
                out_data_reg <= {sat32(by_w), sat32(bx_w), sat32(ay_w), sat32(ax_w)};
            else
                out_data_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // ---------------- checks
    `CCI_ASSERT_IMP(a_no_points, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)
    `CCI_ASSERT_IMP(a_stall_holds_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `CCI_ASSERT_NXT(a_tangent_equal, en && s9_vld_reg && (s9_status_reg == ST_OK) && (s9_rx_reg == '0) && (s9_ry_reg == '0), (m_axis_tdata[31:0] == m_axis_tdata[95:64]) && (m_axis_tdata[63:32] == m_axis_tdata[127:96]))

endmodule

### rtl/cci_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cci_pkg.
`timescale 1ns / 1ps
module cci_sqrt_pipe
    import cci_pkg::*;
#(
    parameter int RADICAND_W = 2 * ROOT_W,
    parameter int SB_W       = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [RADICAND_W-1:0]   radicand,
    input  logic [SB_W-1:0]         sb_in,
    output logic                    out_valid,
    output logic [RADICAND_W/2-1:0] root,
    output logic [SB_W-1:0]         sb_out
);

    localparam int N  = RADICAND_W / 2;
    localparam int RW = N + 2;

    logic [RW-1:0]         rem_reg  [N];
    logic [N-1:0]          root_reg [N];
    logic [RADICAND_W-1:0] rad_reg  [N];
    logic [SB_W-1:0]       sb_reg   [N];
    logic                  vld_reg  [N];

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_stage
            logic [RW-1:0]         rem_prev;
            logic [N-1:0]          root_prev;
            logic [RADICAND_W-1:0] rad_prev;
            logic [SB_W-1:0]       sb_prev;
            logic                  vld_prev;
            logic [RW-1:0]         rem_sh;
            logic [RW-1:0]         trial;
            logic [RW-1:0]         rem_next;
            logic [N-1:0]          root_next;

            if (k == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = radicand;
                assign sb_prev   = sb_in;
                assign vld_prev  = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign sb_prev   = sb_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
            end

            always_comb
            begin
                rem_sh = {rem_prev[RW-3:0], rad_prev[RADICAND_W-1 -: 2]};
                trial  = {root_prev, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[N-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[N-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= {rad_prev[RADICAND_W-3:0], 2'b00};
                    sb_reg[k]   <= sb_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign sb_out    = sb_reg[N-1];

endmodule

### rtl/cci_div_pipe.sv
// Pipelined restoring divider, several lanes sharing one divisor.
// Depends on cci_pkg. Numerator high part must stay below the divisor.
`timescale 1ns / 1ps
module cci_div_pipe
    import cci_pkg::*;
#(
    parameter int DEN_W = D2_W,
    parameter int QW    = QUO_W,
    parameter int LANES = NUM_LANES,
    parameter int SB_W  = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DEN_W+QW-1:0]   num [LANES],
    input  logic [DEN_W-1:0]      den,
    input  logic [SB_W-1:0]       sb_in,
    output logic                  out_valid,
    output logic [QW-1:0]         quo [LANES],
    output logic [SB_W-1:0]       sb_out
);

    localparam int NUM_W = DEN_W + QW;

    logic [DEN_W-1:0] rem_reg [QW][LANES];
    logic [QW-1:0]    lo_reg  [QW][LANES];
    logic [QW-1:0]    q_reg   [QW][LANES];
    logic [DEN_W-1:0] den_reg [QW];
    logic [SB_W-1:0]  sb_reg  [QW];
    logic             vld_reg [QW];

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_stage
            logic [DEN_W-1:0] rem_prev  [LANES];
            logic [QW-1:0]    lo_prev   [LANES];
            logic [QW-1:0]    q_prev    [LANES];
            logic [DEN_W-1:0] den_prev;
            logic [SB_W-1:0]  sb_prev;
            logic             vld_prev;
            logic [DEN_W-1:0] rem_next  [LANES];
            logic [QW-1:0]    q_next    [LANES];

            if (k == 0)
            begin : g_first
                for (genvar l = 0; l < LANES; l++)
                begin : g_lane
                    assign rem_prev[l] = num[l][NUM_W-1:QW];
                    assign lo_prev[l]  = num[l][QW-1:0];
                    assign q_prev[l]   = '0;
                end
                assign den_prev = den;
                assign sb_prev  = sb_in;
                assign vld_prev = in_valid;
            end
            else
            begin : g_rest
                for (genvar l = 0; l < LANES; l++)
                begin : g_lane
                    assign rem_prev[l] = rem_reg[k-1][l];
                    assign lo_prev[l]  = lo_reg[k-1][l];
                    assign q_prev[l]   = q_reg[k-1][l];
                end
                assign den_prev = den_reg[k-1];
                assign sb_prev  = sb_reg[k-1];
                assign vld_prev = vld_reg[k-1];
            end

            always_comb
            begin
                logic [DEN_W:0] rem_sh;
                logic           ge;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_sh = {rem_prev[l], lo_prev[l][QW-1]};
                    ge     = (rem_sh >= {1'b0, den_prev});
                    if (ge)
                        rem_next[l] = DEN_W'(rem_sh - {1'b0, den_prev});
                    else
                        rem_next[l] = rem_sh[DEN_W-1:0];
                    q_next[l] = {q_prev[l][QW-2:0], ge};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_reg[k][l] <= rem_next[l];
                        lo_reg[k][l]  <= {lo_prev[l][QW-2:0], 1'b0};
                        q_reg[k][l]   <= q_next[l];
                    end
                    den_reg[k] <= den_prev;
                    sb_reg[k]  <= sb_prev;
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = q_reg[QW-1][l];
    end

    assign out_valid = vld_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];

endmodule

### sim/testbench.sv
// Self-checking bench for circle_circle_intersection_core: circle pairs in, points out.
// Depends on cci_pkg and the core RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module testbench;
    import cci_pkg::*;

    typedef struct {
        logic signed [31:0] x0, y0, x1, y1;
        logic [30:0]        r0, r1;
    } circle_pair_t;

    typedef struct {
        status_t            status;
        logic signed [31:0] ax, ay, bx, by;
    } crossing_t;

    // predicted crossings, oldest first; checks results in order
    class crossing_board;
        crossing_t pending[$];
        int        errors;
        int        checked;
        int        by_status[4];

        function automatic logic [63:0] root_floor(logic [127:0] v);
            logic [63:0]  s;
            logic [63:0]  c;
            s = 0;
            for (int b = 63; b >= 0; b--) begin
                c = s | (64'd1 << b);
                if ({64'd0, c} * {64'd0, c} <= v)
                    s = c;
            end
            return s;
        endfunction

        // round(n / (2*d2)), halves up, low 64 bits
        function automatic logic [63:0] round_half(logic [127:0] n, logic [63:0] d2);
            logic [127:0] q;
            q = (n + {64'd0, d2}) / {64'd0, d2};
            return q[64:1];
        endfunction

        function automatic logic signed [31:0] clamp32(logic signed [66:0] v);
            if (v > 67'sd2147483647)
                return 32'sh7fffffff;
            if (v < -67'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function automatic crossing_t predict(circle_pair_t p);
            crossing_t    r;
            logic signed [33:0] dx, dy;
            logic [32:0]  adx, ady, sum, dif;
            logic [64:0]  d2w;
            logic [63:0]  d2, a2, b2, km, s, mx, my, ox, oy;
            logic         kneg;
            logic signed [66:0] x2, y2, rx, ry;
            r = '{ST_OK, 0, 0, 0, 0};
            dx  = $signed(p.x1) - $signed(p.x0);
            dy  = $signed(p.y1) - $signed(p.y0);
            adx = 33'(dx < 0 ? -dx : dx);
            ady = 33'(dy < 0 ? -dy : dy);
            d2w = {32'd0, adx} * adx + {32'd0, ady} * ady;
            d2  = d2w[63:0];
            sum = p.r0 + p.r1;
            dif = p.r0 >= p.r1 ? p.r0 - p.r1 : p.r1 - p.r0;
            if (d2w[64] || {1'b0, d2} > {32'd0, sum} * sum)
                r.status = ST_FAR;
            else if ({1'b0, d2} < {32'd0, dif} * dif)
                r.status = ST_INSIDE;
            else if (d2 == 0)
                r.status = ST_SAME;
            if (r.status != ST_OK)
                return r;
            a2 = {33'd0, p.r0} * p.r0;
            b2 = {33'd0, p.r1} * p.r1;
            kneg = 0;
            if (a2 >= b2)
                km = d2 + (a2 - b2);
            else if (d2 >= b2 - a2)
                km = d2 - (b2 - a2);
            else
            begin
                km = (b2 - a2) - d2;
                kneg = 1;
            end
            s  = root_floor({64'd0, {31'd0, sum} * sum - d2} * {64'd0, d2 - {31'd0, dif} * dif});
            mx = round_half({95'd0, adx} * km, d2);
            my = round_half({95'd0, ady} * km, d2);
            ox = round_half({95'd0, ady} * s, d2);
            oy = round_half({95'd0, adx} * s, d2);
            // magnitudes are at most 64 bits, so the 67-bit signed sums cannot overflow
            x2 = ((dx < 0) != kneg) ? p.x0 - $signed({3'd0, mx}) : p.x0 + $signed({3'd0, mx});
            y2 = ((dy < 0) != kneg) ? p.y0 - $signed({3'd0, my}) : p.y0 + $signed({3'd0, my});
            rx = (dy > 0) ? -$signed({3'd0, ox}) : $signed({3'd0, ox});
            ry = (dx < 0) ? -$signed({3'd0, oy}) : $signed({3'd0, oy});
            r.ax = clamp32(x2 + rx);
            r.ay = clamp32(y2 + ry);
            r.bx = clamp32(x2 - rx);
            r.by = clamp32(y2 - ry);
            return r;
        endfunction

        function void note_pair(circle_pair_t p);
            pending.push_back(predict(p));
        endfunction

        function void check_crossing(crossing_t got);
            crossing_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d", $time, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            by_status[want.status]++;
            if (got.status != want.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.ax != want.ax || got.ay != want.ay ||
                got.bx != want.bx || got.by != want.by)
            begin
                $display("%0t: points exp (%0d,%0d)(%0d,%0d) got (%0d,%0d)(%0d,%0d)",
                    $time, want.ax, want.ay, want.bx, want.by,
                    got.ax, got.ay, got.bx, got.by);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 108;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // x0 y0 r0 x1 y1 r1, zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // a_x a_y b_x b_y
    logic [STATUS_W-1:0]    m_axis_tuser;   // status

    crossing_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_receiver;
    bit  feeding_done;

    circle_circle_intersection_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: random back-pressure, drawn each falling edge
    always @(negedge clk)
        m_axis_tready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        crossing_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tuser);
            got.ax = m_axis_tdata[31:0];
            got.ay = m_axis_tdata[63:32];
            got.bx = m_axis_tdata[95:64];
            got.by = m_axis_tdata[127:96];
            board.check_crossing(got);
        end
    end

    // offer one pair, hold until taken; leaves valid high for back-to-back words
    task automatic send_pair(circle_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b0, p.r1, p.y1, p.x1, p.r0, p.y0, p.x0};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_pair(p);
        @(negedge clk);
    endtask

    task automatic send_circles(int x0, int y0, int r0, int x1, int y1, int r1);
        circle_pair_t p;
        p.x0 = x0; p.y0 = y0; p.r0 = 31'(r0);
        p.x1 = x1; p.y1 = y1; p.r1 = 31'(r1);
        send_pair(p);
    endtask

    function automatic circle_pair_t random_pair();
        circle_pair_t p;
        int span;
        int k;
        k = $urandom_range(9);
        if (k == 0)
        begin
            // raw noise, every bit free
            p.x0 = $urandom; p.y0 = $urandom; p.x1 = $urandom; p.y1 = $urandom;
            p.r0 = 31'($urandom); p.r1 = 31'($urandom);
            return p;
        end
        span = 1 << $urandom_range(30, 4);
        p.x0 = $urandom;
        p.y0 = $urandom;
        p.x1 = p.x0 + $signed($urandom_range(2 * span) - span);
        p.y1 = p.y0 + $signed($urandom_range(2 * span) - span);
        p.r0 = 31'($urandom_range(span));
        p.r1 = 31'($urandom_range(span));
        if (k == 1)
            p.r1 = p.r0;
        if (k == 2)
        begin
            p.x1 = p.x0;
            p.y1 = p.y0;
        end
        return p;
    endfunction

    initial
    begin
        #30_000_000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int waited;
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_receiver = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 54;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // crossing pair, tangent outside and inside, far, nested, same center
        send_circles(0, 0, 32'h50000, 32'h60000, 0, 32'h50000);
        send_circles(0, 0, 32'h10000, 32'h20000, 0, 32'h10000);
        send_circles(0, 0, 32'h30000, 32'h10000, 0, 32'h20000);
        send_circles(0, 0, 32'h10000, 32'h50000, 0, 32'h10000);
        send_circles(0, 0, 32'h80000, 32'h10000, 0, 32'h10000);
        send_circles(7, -9, 32'h10000, 7, -9, 32'h10000);
        send_circles(7, -9, 0, 7, -9, 0);
        send_circles(7, -9, 5, 7, -9, 6);
        // opposite corners overflow the squared distance
        send_circles(32'h80000000, 32'h80000000, 31'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_circles(32'h80000000, 0, 31'h7fffffff, 32'h7fffffff, 0, 31'h7fffffff);
        send_circles(32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                     32'h7ffffff0, 32'h7ffffff0, 31'h7fffffff);
        send_circles(32'h80000000, 32'h80000000, 31'h7fffffff,
                     32'h80000010, 32'h80000000, 31'h7fffffff);
        send_circles(0, 0, 0, 1, 0, 1);
        send_circles(-100, 50, 80, 20, -30, 90);
        send_circles(0, 0, 3, 0, 1, 3);

        for (int i = 0; i < 1335; i++)
        begin
            if (i == 445)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 29;
            end
            if (i == 890)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pair(random_pair());
            if (i == 1000)
            begin
                // stall the receiver long enough to back the pipe up
                hold_receiver = 1'b1;
                fork
                    begin
                        repeat (400) @(negedge clk);
                        hold_receiver = 1'b0;
                    end
                join_none
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge clk);
        $display("checked %0d results: ok %0d, far %0d, inside %0d, same center %0d",
            board.checked, board.by_status[0], board.by_status[1],
            board.by_status[2], board.by_status[3]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/cci_pkg.sv
rtl/cci_sqrt_pipe.sv
rtl/cci_div_pipe.sv
rtl/circle_circle_intersection_core.sv
sim/testbench.sv
